// ===== rtl/core/bsm_pkg.sv =====
// Package for the boxcar smear block: word types, control structs and fixed widths.
// Used by bsm_ctrl, bsm_dp and boxcar_smear_with_edge_hold. No dependencies.
package bsm_pkg;

  localparam int SAMPLE_W  = 32;  // Q16.16 sample width
  localparam int LEN_W     = 6;   // window length register width
  localparam int OUT_IDX_W = 16;  // output ordinal width, wraps

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } bsm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic [OUT_IDX_W-1:0]       output_index;
    logic                       run_end;
  } bsm_out_t;

  typedef struct packed {
    logic in_take;    // capture the input word
    logic div_start;  // load divider with the window sum
    logic out_load;   // load the output register
    logic out_end;    // run_end flag for the loaded word
    logic push;       // move the held sample into the window
    logic tail_inc;   // count one tail push
    logic run_clr;    // clear run state
  } bsm_cmd_t;

  typedef struct packed {
    logic bypass;      // window length is zero
    logic last;        // held sample ends the run
    logic div_busy;
    logic out_free;    // output register can take a word this cycle
    logic tail_final;  // next tail output is the final one
  } bsm_stat_t;

endpackage

// ===== rtl/core/bsm_dp.sv =====
// Datapath of the boxcar smear: window ring memory, running sum, serial divider,
// output register and the window length register. Depends on bsm_pkg.
module bsm_dp
  import bsm_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsm_in_t          in_word_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output bsm_out_t         out_word_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  input  bsm_cmd_t         cmd_i,
  output bsm_stat_t        stat_o
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [LEN_W-1:0]     window_len_q, window_len_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [LEN_W-1:0]     fill_q, fill_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [OUT_IDX_W-1:0] out_cnt_q;
  logic [LEN_W-1:0]     tail_cnt_q;
  logic [CNT_W-1:0]     div_cnt_q;
  logic                 out_valid_q;

  logic [SAMPLE_W-1:0]  x_q;
  logic                 last_q;
  logic [SAMPLE_W-1:0]  rd_q;
  logic [SUM_W-1:0]     quo_q;
  logic [LEN_W:0]       rem_q;
  logic                 neg_q;
  bsm_out_t             out_word_q;

  logic [SAMPLE_W-1:0]  store_mem [WINDOW_MAX];

  logic                 full;
  logic [LEN_W-1:0]     slot_nxt;
  logic [SUM_W-1:0]     x_ext, old_ext, sum_abs;
  logic [LEN_W:0]       trial;
  logic                 trial_ge;
  logic [SUM_W-1:0]     quo_signed;
  logic [SAMPLE_W-1:0]  avg;
  logic                 out_free;

  assign full     = (fill_q >= window_len_q);
  assign slot_nxt = LEN_W'(slot_q) + 1'b1;
  assign x_ext    = {{(SUM_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
  assign old_ext  = full ? {{(SUM_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q} : '0;
  assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(~sum_q + 1'b1) : sum_q;

  assign trial    = {rem_q[LEN_W-1:0], quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, window_len_q});

  assign quo_signed = neg_q ? SUM_W'(~quo_q + 1'b1) : quo_q;
  assign avg        = quo_signed[SAMPLE_W-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    window_len_d = window_len_q;
    slot_d       = slot_q;
    fill_d       = fill_q;
    sum_d        = sum_q;
    if (cfg_we_i) begin
      window_len_d = (cfg_wdata_i > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : cfg_wdata_i;
    end
    if (cmd_i.push) begin
      sum_d  = sum_q - old_ext + x_ext;
      fill_d = full ? fill_q : fill_q + 1'b1;
      slot_d = (slot_nxt >= window_len_q) ? '0 : slot_nxt[IDX_W-1:0];
    end
    if (cfg_we_i || cmd_i.run_clr) begin
      slot_d = '0;
      fill_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= LEN_W'(1);
      slot_q       <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      out_cnt_q    <= '0;
      tail_cnt_q   <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      window_len_q <= window_len_d;
      slot_q       <= slot_d;
      fill_q       <= fill_d;
      sum_q        <= sum_d;
      if (cmd_i.div_start) begin
        div_cnt_q <= CNT_W'(SUM_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      if (cfg_we_i || cmd_i.run_clr) begin
        out_cnt_q  <= '0;
        tail_cnt_q <= '0;
      end else begin
        if (cmd_i.out_load) out_cnt_q <= out_cnt_q + 1'b1;
        if (cmd_i.tail_inc) tail_cnt_q <= tail_cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      x_q    <= in_word_i.sample;
      last_q <= in_word_i.last;
    end
    if (cmd_i.div_start) begin
      quo_q <= sum_abs;
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (div_cnt_q != '0) begin
      // restoring division, one quotient bit a cycle
      rem_q <= trial_ge ? (trial - {1'b0, window_len_q}) : trial;
      quo_q <= {quo_q[SUM_W-2:0], trial_ge};
    end
    if (cmd_i.out_load) begin
      out_word_q.smoothed     <= stat_o.bypass ? x_q : avg;
      out_word_q.output_index <= out_cnt_q;
      out_word_q.run_end      <= cmd_i.out_end;
    end
  end

  // window ring; read always follows the write slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) store_mem[slot_q] <= x_q;
    rd_q <= store_mem[slot_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign stat_o.bypass     = (window_len_q == '0);
  assign stat_o.last       = last_q;
  assign stat_o.div_busy   = (div_cnt_q != '0);
  assign stat_o.out_free   = out_free;
  assign stat_o.tail_final = (tail_cnt_q == window_len_q - 1'b1);

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_len_q <= LEN_W'(WINDOW_MAX))
    else $error("window length above maximum");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= window_len_q)
    else $error("fill count exceeds window length");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> div_cnt_q == '0)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/core/bsm_ctrl.sv =====
// Controller of the boxcar smear: sequences accept, divide, emit and window push.
// Depends on bsm_pkg; drives the datapath through bsm_cmd_t.
module bsm_ctrl
  import bsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bsm_stat_t stat_i,
  output bsm_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT,
    ST_UPD
  } state_e;

  state_e state_q, state_d;
  logic   tail_q, tail_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    tail_d  = tail_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        tail_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.in_take = 1'b1;
          state_d       = stat_i.bypass ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.bypass) begin
            cmd_o.out_end = stat_i.last;
            cmd_o.run_clr = stat_i.last;
            state_d       = ST_IDLE;
          end else if (tail_q && stat_i.tail_final) begin
            cmd_o.out_end = 1'b1;
            cmd_o.run_clr = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.push = 1'b1;
        if (tail_q) begin
          cmd_o.tail_inc = 1'b1;
          state_d        = ST_DIV_GO;
        end else if (stat_i.last) begin
          tail_d  = 1'b1;   // edge hold: repeat the last sample
          state_d = ST_DIV_GO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tail_q  <= tail_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output overwritten while pending");

  a_push_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> !stat_i.bypass)
    else $error("window push in bypass");

  a_div_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !stat_i.div_busy) |=> state_q == ST_EMIT)
    else $error("divide end not followed by emit");

endmodule

// ===== rtl/core/boxcar_smear_with_edge_hold.sv =====
// Boxcar smear with edge hold: trailing moving average with tail repeat of the last word.
// Path: in bypass the input register feeds the output register; otherwise the window sum
// goes through the serial divider (SUM_W = 32 + clog2(WINDOW_MAX+1), 38 at defaults).
// A new input word is taken only once the block is through with the last one; a last word
// adds window_len further outputs, each through the divider. Output stalls hold the emit.
// Reset: window length 1, run state cleared, ring undefined.
module boxcar_smear_with_edge_hold
  import bsm_pkg::*;
#(
  parameter int WINDOW_MAX = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bsm_in_t          in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bsm_out_t         out_word_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  bsm_cmd_t  cmd;
  bsm_stat_t stat;

  bsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== sim/tb_boxcar_smear_with_edge_hold.sv =====
`timescale 1ns / 1ps
// Testbench for boxcar_smear_with_edge_hold: directed and random sample runs, each output
// word checked against a behavioural boxcar predictor held in a small scoreboard class.
// Depends on bsm_pkg and the block's RTL.
module tb_boxcar_smear_with_edge_hold;
  import bsm_pkg::*;

  localparam int WIN_MAX       = 32;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 22;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  class boxcar_tracker;
    bsm_out_t           awaited[$];
    longint             ring[WIN_MAX];
    int unsigned        wlen;
    int unsigned        slot;
    int unsigned        fill;
    longint             wsum;
    bit [OUT_IDX_W-1:0] out_cnt;
    int                 faults;

    function new();
      wlen   = 1;
      faults = 0;
      clear_run();
    endfunction

    function void clear_run();
      slot    = 0;
      fill    = 0;
      wsum    = 0;
      out_cnt = '0;
    endfunction

    function void set_len(int unsigned v);
      wlen = (v > WIN_MAX) ? WIN_MAX : v;
      clear_run();
    endfunction

    function void add_to_ring(longint x);
      if (fill >= wlen) begin
        wsum -= ring[slot];
      end else begin
        fill++;
      end
      ring[slot] = x;
      wsum += x;
      slot = (slot + 1 >= wlen) ? 0 : slot + 1;
    endfunction

    // signed division truncates toward zero, as the block does
    function longint mean();
      return wsum / longint'(wlen);
    endfunction

    function void queue_average(longint v, bit is_end);
      bsm_out_t w;
      w.smoothed     = v[SAMPLE_W-1:0];
      w.output_index = out_cnt;
      w.run_end      = is_end;
      awaited.insert(awaited.size(), w);
      out_cnt++;
    endfunction

    function void take_sample(bsm_in_t w);
      longint x;
      x = longint'($signed(w.sample));
      if (wlen == 0) begin
        queue_average(x, w.last);
        if (w.last) clear_run();
        return;
      end
      queue_average(mean(), 1'b0);
      add_to_ring(x);
      if (!w.last) return;
      // tail: pad the window with copies of the final sample
      for (int t = 0; t < wlen; t++) begin
        queue_average(mean(), t + 1 == wlen);
        if (t + 1 != wlen) add_to_ring(x);
      end
      clear_run();
    endfunction

    function bit note_fault();
      faults++;
      return 1'b1;
    endfunction

    function void check_average(bsm_out_t got);
      bsm_out_t want;
      if (awaited.size() == 0) begin
        if (note_fault())
          $error("unexpected word: output_index %0d smoothed %0d run_end %0d",
                 got.output_index, got.smoothed, got.run_end);
        return;
      end
      want = awaited.pop_front();
      if (got.smoothed !== want.smoothed && note_fault())
        $error("smoothed: expected %0d, got %0d", want.smoothed, got.smoothed);
      if (got.output_index !== want.output_index && note_fault())
        $error("output_index: expected %0d, got %0d", want.output_index, got.output_index);
      if (got.run_end !== want.run_end && note_fault())
        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  bsm_in_t          in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  bsm_out_t         out_word_o;
  logic             cfg_we_i    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;

  int            send_gap_pct   = 0;
  int            recv_stall_pct = 0;
  int            hold_reqs      = 0;
  int            hold_seen      = 0;
  int            hold_left      = 0;
  longint        cycles         = 0;
  boxcar_tracker tracker;

  boxcar_smear_with_edge_hold #(
    .WINDOW_MAX(WIN_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_boxcar_smear_with_edge_hold: errors");
      $finish;
    end
  end

  // output side: check accepted words, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_average(out_word_o);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last_flag);
    bsm_in_t w;
    w.sample = s;
    w.last   = last_flag;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_len(input int unsigned v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[LEN_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_len(v);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom;
    if (r < 75) return $urandom_range(200) - 100;
    if (r < 85) return S_MAX;
    if (r < 95) return S_MIN;
    return r[0] ? '0 : '1;
  endfunction

  // runs of random length ended by last; the phase may stop mid run
  task automatic random_phase(input int unsigned len, input bit squeeze);
    int sent;
    int run_len;
    write_len(len);
    if (squeeze) hold_reqs++;
    sent = 0;
    while (sent < PHASE_WORDS) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int k = 0; k < run_len && sent < PHASE_WORDS; k++) begin
        send_word(pick_sample(), k == run_len - 1);
        sent++;
        if (squeeze && sent == PHASE_WORDS / 2) wait_drained();
      end
    end
  endtask

  initial begin
    int unsigned fixed_lens[6];
    fixed_lens = '{32, 0, 1, 63, 2, 33};
    tracker = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 34;
    recv_stall_pct = 56;

    // window length 1 out of reset
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b0);
    send_word(-1, 1'b1);

    // bypass
    write_len(0);
    send_word(S_MAX, 1'b0);
    send_word(S_MIN, 1'b1);
    send_word(0, 1'b0);
    send_word(-1, 1'b1);

    // full window: a lone last word fills all 32 slots from the tail
    write_len(32);
    send_word(S_MIN, 1'b1);
    send_word(S_MAX, 1'b1);
    send_word(1, 1'b0);
    send_word(-1, 1'b0);
    send_word(32'h1234_5678, 1'b1);

    // oversized length saturates
    write_len(63);
    send_word(S_MAX, 1'b0);
    send_word(-5, 1'b1);

    // rewrite mid run clears the run; small negative sums truncate toward zero
    write_len(5);
    send_word(-1, 1'b0);
    send_word(-2, 1'b0);
    send_word(7, 1'b0);
    write_len(3);
    send_word(-1, 1'b0);
    send_word(-2, 1'b0);
    send_word(7, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_gap_pct   = 34;
        recv_stall_pct = 56;
      end else if (p < 8) begin
        send_gap_pct   = 56;
        recv_stall_pct = 34;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      random_phase((p < 6) ? fixed_lens[p] : $urandom_range(63), p == 8);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("tb_boxcar_smear_with_edge_hold: clean");
    end else begin
      $display("tb_boxcar_smear_with_edge_hold: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bsm_pkg.sv
rtl/core/bsm_dp.sv
rtl/core/bsm_ctrl.sv
rtl/core/boxcar_smear_with_edge_hold.sv
sim/tb_boxcar_smear_with_edge_hold.sv
